// ----- rtl/lscp_pkg.sv -----
// Package for the line sensor calibrate and position block.
// Types, widths, command codes and the scale-by-1000 helper.
// No dependencies.
package lscp_pkg;

   localparam int NUM_SENSORS = 6;
   localparam int RAW_BITS    = 16;
   localparam int CMD_W       = 2;
   localparam int LEVEL_W     = 10;
   localparam int SUM_W       = 13;
   localparam int POS_W       = 13;
   localparam int FULL_SCALE  = 1000;

   localparam int IDX_W  = $clog2(NUM_SENSORS);
   localparam int WGT_W  = $clog2(NUM_SENSORS + 1);
   localparam int WSUM_W = $clog2(FULL_SCALE * NUM_SENSORS * (NUM_SENSORS + 1) / 2 + 1);

   // divider geometry: one remainder width and one quotient length serve
   // both the level and the position divisions
   localparam int DIV_A = (RAW_BITS > SUM_W) ? RAW_BITS : SUM_W;
   localparam int DIV_W = (DIV_A > WSUM_W) ? DIV_A : WSUM_W;
   localparam int Q_W   = (POS_W > LEVEL_W) ? POS_W : LEVEL_W;
   localparam int DVD_W = DIV_W + Q_W;
   localparam int CNT_W = $clog2(Q_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR     = 2'd0,
      CMD_CALIBRATE = 2'd1,
      CMD_MEASURE   = 2'd2
   } cmd_type;

   typedef logic [RAW_BITS-1:0]                   raw_type;
   typedef logic [LEVEL_W-1:0]                    level_type;
   typedef logic [IDX_W-1:0]                      idx_type;
   typedef logic [NUM_SENSORS-1:0][RAW_BITS-1:0]  raw_vec_type;
   typedef logic [NUM_SENSORS-1:0][LEVEL_W-1:0]   level_vec_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      raw_type          raw_0;
      raw_type          raw_1;
      raw_type          raw_2;
      raw_type          raw_3;
      raw_type          raw_4;
      raw_type          raw_5;
   } req_type;

   typedef struct packed {
      level_type        level_0;
      level_type        level_1;
      level_type        level_2;
      level_type        level_3;
      level_type        level_4;
      level_type        level_5;
      logic [SUM_W-1:0] level_sum;
      logic [POS_W-1:0] line_position;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic calibrate;
   } mark_ctl_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;

   // v * 1000 as 1024 - 16 - 8
   function automatic logic [DVD_W-1:0] times_scale(input logic [DIV_W-1:0] v);
      logic [DVD_W-1:0] e;
      e = DVD_W'(v);
      return (e << 10) - (e << 4) - (e << 3);
   endfunction

endpackage

// ----- rtl/lscp_serdiv.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lscp_pkg.
module lscp_serdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  lscp_pkg::div_req_type req,
   output lscp_pkg::div_rsp_type rsp
);
   import lscp_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [Q_W-1:0]   sh_ff, sh_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;

   // caller guarantees dividend < divisor * 2**Q_W
   assign trial = {rem_ff, sh_ff[Q_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      sh_in   = sh_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.dividend[DVD_W-1:Q_W];
         sh_in   = req.dividend[Q_W-1:0];
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         sh_in  = {sh_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      sh_ff  <= sh_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = sh_ff;

endmodule

// ----- rtl/lscp_marks.sv -----
// Per-sensor calibration store: running minimum and maximum of raw times.
// Depends on lscp_pkg.
module lscp_marks (
   input  logic                  clock,
   input  logic                  reset,
   input  lscp_pkg::mark_ctl_type ctl,
   input  lscp_pkg::raw_vec_type  raw,
   input  lscp_pkg::idx_type      rd_idx,
   output lscp_pkg::raw_type      rd_low,
   output lscp_pkg::raw_type      rd_high
);
   import lscp_pkg::*;

   raw_vec_type low_ff, low_in;
   raw_vec_type high_ff, high_in;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (ctl.clear) begin
            low_in[i]  = '1;
            high_in[i] = '0;
         end else if (ctl.calibrate) begin
            if (raw[i] < low_ff[i]) begin
               low_in[i] = raw[i];
            end
            if (raw[i] > high_ff[i]) begin
               high_in[i] = raw[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            low_ff[i]  <= '1;
            high_ff[i] <= '0;
         end
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign rd_low  = low_ff[rd_idx];
   assign rd_high = high_ff[rd_idx];

endmodule

// ----- rtl/line_sensor_calibrate_and_position_top.sv -----
// Line sensor calibrate and position: top level, sequencer and result register.
// Depends on lscp_pkg, lscp_marks and lscp_serdiv.
//
// Each request transaction carries a command and six raw discharge times.
// Clear and calibrate return nothing and leave the block idle, so it is
// ready again in the next cycle. Measure returns one response transaction with
// six levels in 0..1000, their sum and the weighted line position. In a
// measure, sensors are normalised one after another through a single
// bit-serial divider, each with a set-up step before its division and an
// accumulate step after it; a sensor whose level saturates or whose raw value
// lies outside its range skips the divider, and the position takes one more
// division unless the sum is zero. req_stall is high while a measure is in
// progress; a finished response waits in its output register without
// blocking a following clear or calibrate.
module line_sensor_calibrate_and_position_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lscp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lscp_pkg::rsp_type rsp_data
);
   import lscp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PREP   = 7'b0000010,
      ST_LVL    = 7'b0000100,
      ST_ACC    = 7'b0001000,
      ST_PSTART = 7'b0010000,
      ST_POS    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   idx_type          idx_ff, idx_in;
   raw_vec_type      raw_ff, raw_in;
   level_type        lvl_ff, lvl_in;
   level_vec_type    lvl_sh_ff, lvl_sh_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   raw_vec_type      req_raw;
   logic             req_accept;
   mark_ctl_type     mark_ctl;
   raw_type          mk_low, mk_high;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // per-sensor set-up terms
   raw_type          raw_cur;
   logic             rng_up, rng_dn, live_up, live_dn;
   raw_type          num_sel, den_sel;
   logic [WGT_W-1:0] weight;
   logic [WSUM_W-1:0] wprod;

   assign req_raw[0] = req_data.raw_0;
   assign req_raw[1] = req_data.raw_1;
   assign req_raw[2] = req_data.raw_2;
   assign req_raw[3] = req_data.raw_3;
   assign req_raw[4] = req_data.raw_4;
   assign req_raw[5] = req_data.raw_5;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   lscp_marks u_marks (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mark_ctl),
      .raw     (req_raw),
      .rd_idx  (idx_ff),
      .rd_low  (mk_low),
      .rd_high (mk_high)
   );

   lscp_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The current sensor always sits at the bottom of the raw shift line.
   // Normal range (high above low): level grows from low upwards.
   // Inverted range: the signed formula reduces to (low - raw) / (low - high),
   // so only raw at or below low gives a non-zero level.
   assign raw_cur = raw_ff[0];
   assign rng_up  = (mk_high > mk_low);
   assign rng_dn  = (mk_low > mk_high);
   assign live_up = rng_up && (raw_cur >= mk_low);
   assign live_dn = rng_dn && (raw_cur <= mk_low);
   assign num_sel = live_up ? (raw_cur - mk_low) : (mk_low - raw_cur);
   assign den_sel = rng_up ? (mk_high - mk_low) : (mk_low - mk_high);

   assign weight = WGT_W'(idx_ff) + 1'b1;
   assign wprod  = WSUM_W'(lvl_ff) * WSUM_W'(weight);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      raw_in       = raw_ff;
      lvl_in       = lvl_ff;
      lvl_sh_in    = lvl_sh_ff;
      sum_in       = sum_ff;
      wsum_in      = wsum_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mark_ctl     = '0;
      div_req      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // code 3 falls through every test and is dropped
               mark_ctl.clear     = (req_data.cmd == CMD_CLEAR);
               mark_ctl.calibrate = (req_data.cmd == CMD_CALIBRATE);
               if (req_data.cmd == CMD_MEASURE) begin
                  raw_in   = req_raw;
                  idx_in   = '0;
                  sum_in   = '0;
                  wsum_in  = '0;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (!(live_up || live_dn)) begin
               lvl_in   = '0;
               state_in = ST_ACC;
            end else if (num_sel >= den_sel) begin
               lvl_in   = LEVEL_W'(FULL_SCALE);
               state_in = ST_ACC;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = times_scale(DIV_W'(num_sel));
               div_req.divisor  = DIV_W'(den_sel);
               state_in         = ST_LVL;
            end
         end
         ST_LVL: begin
            if (div_rsp.done) begin
               lvl_in   = div_rsp.quotient[LEVEL_W-1:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in    = sum_ff + SUM_W'(lvl_ff);
            wsum_in   = wsum_ff + wprod;
            lvl_sh_in = {lvl_ff, lvl_sh_ff[NUM_SENSORS-1:1]};
            for (int i = 0; i < NUM_SENSORS - 1; i++) begin
               raw_in[i] = raw_ff[i+1];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(NUM_SENSORS - 1)) begin
               state_in = ST_PSTART;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PSTART: begin
            if (sum_ff == '0) begin
               pos_in   = '0;
               state_in = ST_DONE;
            end else begin
               // weighted sum holds sum(level * (index + 1)); the 1000 goes in here
               div_req.start    = 1'b1;
               div_req.dividend = times_scale(DIV_W'(wsum_ff));
               div_req.divisor  = DIV_W'(sum_ff);
               state_in         = ST_POS;
            end
         end
         ST_POS: begin
            if (div_rsp.done) begin
               pos_in   = div_rsp.quotient[POS_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load only once the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.level_0       = lvl_sh_ff[0];
               rsp_data_in.level_1       = lvl_sh_ff[1];
               rsp_data_in.level_2       = lvl_sh_ff[2];
               rsp_data_in.level_3       = lvl_sh_ff[3];
               rsp_data_in.level_4       = lvl_sh_ff[4];
               rsp_data_in.level_5       = lvl_sh_ff[5];
               rsp_data_in.level_sum     = sum_ff;
               rsp_data_in.line_position = pos_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      lvl_ff      <= lvl_in;
      lvl_sh_ff   <= lvl_sh_in;
      sum_ff      <= sum_in;
      wsum_ff     <= wsum_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/lscp_checker.sv -----
// Port-level checks for the line sensor calibrate and position top level,
// bound to it below. Depends on lscp_pkg.
module lscp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lscp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lscp_pkg::rsp_type rsp_data
);
   import lscp_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a measure keeps the block busy in the following cycle
   a_measure_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_MEASURE |=> req_stall)
      else $error("no stall after measure");

   // clear, calibrate and the unused code leave the block free in the following cycle
   a_other_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd != CMD_MEASURE |=> !req_stall)
      else $error("stall after single-cycle command");

   // a fresh response only comes out of a measure in progress
   a_rsp_from_measure: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a measure");

endmodule

bind line_sensor_calibrate_and_position_top lscp_checker u_checker (.*);
